### hdl/sbrd_pkg.sv
// Package for the sub-CPU bus decoder with the double-buffered road RAM.
// Holds store sizes, the address map, action codes and the structs shared by the decoder, result stage and top level.
// Depends on nothing.
package sbrd_pkg;

    // Store depths are powers of two; word indexes wrap on their low bits.
    localparam int ROM_WORDS      = 131072;
    localparam int WORK_RAM_WORDS = 16384;
    localparam int ROAD_WORDS     = 2048;

    localparam int ROM_AW  = $clog2(ROM_WORDS);
    localparam int WRAM_AW = $clog2(WORK_RAM_WORDS);
    localparam int ROAD_AW = $clog2(ROAD_WORDS);

    // The clearing pass covers the deeper of the two zero-reset stores.
    localparam int CLR_WORDS = (WORK_RAM_WORDS > ROAD_WORDS) ? WORK_RAM_WORDS : ROAD_WORDS;
    localparam int CLR_AW    = $clog2(CLR_WORDS);

    // Address map of the sub bus.
    localparam logic [19:0] ROM_END     = 20'h5ffff;
    localparam logic [19:0] WRAM_BEG    = 20'h60000;
    localparam logic [19:0] WRAM_WR_END = 20'h67fff;
    localparam logic [19:0] WRAM_END    = 20'h7ffff;
    localparam logic [19:0] ROAD_BEG    = 20'h80000;
    localparam logic [19:0] ROAD_END    = 20'h8ffff;
    localparam logic [19:0] SWAP_BEG    = 20'h90000;
    localparam logic [19:0] SWAP_END    = 20'h9ffff;

    // Action codes.
    localparam logic [2:0] ACT_WORD_RD = 3'd0;
    localparam logic [2:0] ACT_WORD_WR = 3'd1;
    localparam logic [2:0] ACT_BYTE_RD = 3'd2;
    localparam logic [2:0] ACT_BYTE_WR = 3'd3;
    localparam logic [2:0] ACT_ROAD_RD = 3'd4;
    localparam logic [2:0] ACT_ROM_LD  = 3'd5;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_ONES,
        SRC_ROM,
        SRC_WRAM,
        SRC_ROAD_CPU,
        SRC_ROAD_SHOWN
    } t_src;

    typedef struct packed {
        logic [2:0]  action;
        logic [19:0] address;
        logic [15:0] write_data;
        logic [16:0] side_index;
    } t_cmd;

    typedef struct packed {
        logic [15:0] read_data;
        logic [1:0]  road_mode;
    } t_rsp;

    // Decoded request: write strobes per byte lane, addresses and read source.
    typedef struct packed {
        logic               rom_we;
        logic               wram_we_hi;
        logic               wram_we_lo;
        logic               road_we_hi;
        logic               road_we_lo;
        logic               ctrl_we;
        logic [1:0]         ctrl_val;
        logic               swap;
        logic [7:0]         wdata_hi;
        logic [7:0]         wdata_lo;
        logic [ROM_AW-1:0]  rom_raddr;
        logic [ROM_AW-1:0]  rom_waddr;
        logic [WRAM_AW-1:0] wram_addr;
        logic [ROAD_AW-1:0] road_cpu_addr;
        logic [ROAD_AW-1:0] road_side_addr;
        t_src               src;
        logic               byte_rd;
        logic               odd;
    } t_dec;

    // What the result stage needs to pick and shape the read word.
    typedef struct packed {
        t_src src;
        logic road_b;
        logic byte_rd;
        logic odd;
    } t_sel;

endpackage

### hdl/sbrd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module sbrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/sbrd_decode.sv
// Address and action decoder for the sub bus: write strobes, store addresses, read source.
// Depends on sbrd_pkg.
module sbrd_decode (
    input  sbrd_pkg::t_cmd i_cmd,
    output sbrd_pkg::t_dec o_dec
);
    import sbrd_pkg::*;

    logic [19:0] a;
    logic        in_rom;
    logic        in_wram;
    logic        wram_wr_ok;
    logic        in_road;
    logic        in_swap;
    t_src        peek_src;

    assign a          = i_cmd.address;
    assign in_rom     = (a <= ROM_END);
    assign in_wram    = (a >= WRAM_BEG) && (a <= WRAM_END);
    assign wram_wr_ok = (a >= WRAM_BEG) && (a <= WRAM_WR_END);
    assign in_road    = (a >= ROAD_BEG) && (a <= ROAD_END);
    assign in_swap    = (a >= SWAP_BEG) && (a <= SWAP_END);

    // Plain read source; unmapped space reads as all ones.
    always_comb begin
        if (in_rom) begin
            peek_src = SRC_ROM;
        end else if (in_wram) begin
            peek_src = SRC_WRAM;
        end else if (in_road) begin
            peek_src = SRC_ROAD_CPU;
        end else begin
            peek_src = SRC_ONES;
        end
    end

    always_comb begin
        o_dec                = '0;
        o_dec.src            = SRC_ZERO;
        o_dec.rom_raddr      = a[ROM_AW:1];
        o_dec.rom_waddr      = i_cmd.side_index[ROM_AW-1:0];
        o_dec.wram_addr      = a[WRAM_AW:1];
        o_dec.road_cpu_addr  = a[ROAD_AW:1];
        o_dec.road_side_addr = i_cmd.side_index[ROAD_AW-1:0];
        o_dec.ctrl_val       = i_cmd.write_data[1:0];
        o_dec.wdata_hi       = i_cmd.write_data[15:8];
        o_dec.wdata_lo       = i_cmd.write_data[7:0];
        o_dec.odd            = a[0];
        case (i_cmd.action)
            ACT_WORD_RD: begin
                o_dec.swap = in_swap;
                o_dec.src  = in_swap ? SRC_ONES : peek_src;
            end
            ACT_WORD_WR: begin
                o_dec.wram_we_hi = wram_wr_ok;
                o_dec.wram_we_lo = wram_wr_ok;
                o_dec.road_we_hi = in_road;
                o_dec.road_we_lo = in_road;
                o_dec.ctrl_we    = in_swap;
            end
            ACT_BYTE_RD: begin
                o_dec.byte_rd = 1'b1;
                o_dec.swap    = in_swap && !a[0];
                o_dec.src     = in_swap ? SRC_ONES : peek_src;
            end
            ACT_BYTE_WR: begin
                // The byte goes to both lanes; only the addressed lane is strobed.
                o_dec.wdata_hi   = i_cmd.write_data[7:0];
                o_dec.wram_we_hi = wram_wr_ok && !a[0];
                o_dec.wram_we_lo = wram_wr_ok && a[0];
                o_dec.road_we_hi = in_road && !a[0];
                o_dec.road_we_lo = in_road && a[0];
                o_dec.ctrl_we    = in_swap;
            end
            ACT_ROAD_RD: begin
                o_dec.src = SRC_ROAD_SHOWN;
            end
            ACT_ROM_LD: begin
                o_dec.rom_we = 1'b1;
            end
            default: begin
                o_dec.src = SRC_ZERO;
            end
        endcase
    end

endmodule

### hdl/sbrd_result.sv
// Result stage: picks the word from the store read data, extracts bytes, registers the result.
// Depends on sbrd_pkg.
module sbrd_result (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  sbrd_pkg::t_sel     i_sel,
    input  logic [1:0]         i_mode,
    input  logic [15:0]        i_rom_q,
    input  logic [15:0]        i_wram_q,
    input  logic [15:0]        i_road_a_q,
    input  logic [15:0]        i_road_b_q,
    output logic               o_done,
    output sbrd_pkg::t_rsp     o_rsp
);
    import sbrd_pkg::*;

    logic [15:0] word;
    logic [15:0] n_data;

    always_comb begin
        case (i_sel.src)
            SRC_ONES:       word = 16'hffff;
            SRC_ROM:        word = i_rom_q;
            SRC_WRAM:       word = i_wram_q;
            SRC_ROAD_CPU,
            SRC_ROAD_SHOWN: word = i_sel.road_b ? i_road_b_q : i_road_a_q;
            default:        word = 16'h0000;
        endcase
    end

    // An even address selects the high byte.
    always_comb begin
        if (i_sel.byte_rd) begin
            n_data = {8'h00, (i_sel.odd ? word[7:0] : word[15:8])};
        end else begin
            n_data = word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_vld;
        end
        o_rsp.read_data <= n_data;
        o_rsp.road_mode <= i_mode;
    end

endmodule

### hdl/sub_cpu_bus_with_road_double_buffer.sv
// Top level of the sub-CPU bus decoder with the double-buffered road RAM.
// Depends on sbrd_pkg, sbrd_decode, sbrd_ram and sbrd_result.
//
//  channel   ports                    handshake
//  -------   ----------------------   -------------------------------------------
//  command   i_cmd, i_start, o_busy   transfer when i_start is high and o_busy low
//  result    o_rsp, o_done            one cycle strobe, always taken
//
// One command is taken every cycle while o_busy is low; its result appears with o_done
// after the registered read of the store RAMs and the result register.
// After reset a clearing pass zeroes work RAM and both road banks with o_busy high;
// program ROM is not cleared.
// The result side has no stall, so o_busy is high only during the clearing pass.
module sub_cpu_bus_with_road_double_buffer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  sbrd_pkg::t_cmd  i_cmd,
    output logic            o_done,
    output sbrd_pkg::t_rsp  o_rsp
);
    import sbrd_pkg::*;

    localparam logic [CLR_AW-1:0] CLR_LAST = CLR_AW'(CLR_WORDS - 1);

    t_dec               dec;
    logic               accept;

    logic               r_clearing;
    logic [CLR_AW-1:0]  r_clr_cnt;
    logic               clr_wram;
    logic               clr_road;

    logic               r_bank_sel;
    logic               n_bank_sel;
    logic [1:0]         r_ctrl;
    logic [1:0]         n_ctrl;

    logic               r_s1_vld;
    t_sel               r_s1_sel;
    logic [1:0]         r_s1_mode;

    logic               wram_we_hi;
    logic               wram_we_lo;
    logic [7:0]         wram_wd_hi;
    logic [7:0]         wram_wd_lo;
    logic [WRAM_AW-1:0] wram_waddr;

    logic               road_a_we_hi;
    logic               road_a_we_lo;
    logic               road_b_we_hi;
    logic               road_b_we_lo;
    logic [7:0]         road_wd_hi;
    logic [7:0]         road_wd_lo;
    logic [ROAD_AW-1:0] road_waddr;
    logic [ROAD_AW-1:0] road_a_raddr;
    logic [ROAD_AW-1:0] road_b_raddr;

    logic [15:0]        rom_q;
    logic [15:0]        wram_q;
    logic [15:0]        road_a_q;
    logic [15:0]        road_b_q;

    sbrd_decode u_decode (
        .i_cmd (i_cmd),
        .o_dec (dec)
    );

    assign accept = i_start && !r_clearing;
    assign o_busy = r_clearing;

    assign clr_wram = r_clearing && ({1'b0, r_clr_cnt} < (CLR_AW + 1)'(WORK_RAM_WORDS));
    assign clr_road = r_clearing && ({1'b0, r_clr_cnt} < (CLR_AW + 1)'(ROAD_WORDS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == CLR_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // A swap only flips r_bank_sel, which exchanges the CPU bank and the displayed bank.
    assign n_bank_sel = r_bank_sel ^ (accept && dec.swap);
    assign n_ctrl     = (accept && dec.ctrl_we) ? dec.ctrl_val : r_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_sel <= 1'b0;
            r_ctrl     <= 2'd0;
            r_s1_vld   <= 1'b0;
        end else begin
            r_bank_sel <= n_bank_sel;
            r_ctrl     <= n_ctrl;
            r_s1_vld   <= accept;
        end
        r_s1_sel.src     <= dec.src;
        r_s1_sel.road_b  <= (dec.src == SRC_ROAD_CPU) ? r_bank_sel : !r_bank_sel;
        r_s1_sel.byte_rd <= dec.byte_rd;
        r_s1_sel.odd     <= dec.odd;
        r_s1_mode        <= n_ctrl;
    end

    // Program ROM.
    sbrd_ram #(.WIDTH(8), .DEPTH(ROM_WORDS)) u_rom_hi (
        .i_clk   (i_clk),
        .i_we    (accept && dec.rom_we),
        .i_waddr (dec.rom_waddr),
        .i_wdata (dec.wdata_hi),
        .i_raddr (dec.rom_raddr),
        .o_rdata (rom_q[15:8])
    );

    sbrd_ram #(.WIDTH(8), .DEPTH(ROM_WORDS)) u_rom_lo (
        .i_clk   (i_clk),
        .i_we    (accept && dec.rom_we),
        .i_waddr (dec.rom_waddr),
        .i_wdata (dec.wdata_lo),
        .i_raddr (dec.rom_raddr),
        .o_rdata (rom_q[7:0])
    );

    // Work RAM, one RAM per byte lane.
    assign wram_we_hi = r_clearing ? clr_wram : (accept && dec.wram_we_hi);
    assign wram_we_lo = r_clearing ? clr_wram : (accept && dec.wram_we_lo);
    assign wram_wd_hi = r_clearing ? 8'h00 : dec.wdata_hi;
    assign wram_wd_lo = r_clearing ? 8'h00 : dec.wdata_lo;
    assign wram_waddr = r_clearing ? r_clr_cnt[WRAM_AW-1:0] : dec.wram_addr;

    sbrd_ram #(.WIDTH(8), .DEPTH(WORK_RAM_WORDS)) u_wram_hi (
        .i_clk   (i_clk),
        .i_we    (wram_we_hi),
        .i_waddr (wram_waddr),
        .i_wdata (wram_wd_hi),
        .i_raddr (dec.wram_addr),
        .o_rdata (wram_q[15:8])
    );

    sbrd_ram #(.WIDTH(8), .DEPTH(WORK_RAM_WORDS)) u_wram_lo (
        .i_clk   (i_clk),
        .i_we    (wram_we_lo),
        .i_waddr (wram_waddr),
        .i_wdata (wram_wd_lo),
        .i_raddr (dec.wram_addr),
        .o_rdata (wram_q[7:0])
    );

    // Road banks: the CPU side takes bus addresses, the displayed side takes the side index.
    assign road_a_we_hi = r_clearing ? clr_road : (accept && dec.road_we_hi && !r_bank_sel);
    assign road_a_we_lo = r_clearing ? clr_road : (accept && dec.road_we_lo && !r_bank_sel);
    assign road_b_we_hi = r_clearing ? clr_road : (accept && dec.road_we_hi && r_bank_sel);
    assign road_b_we_lo = r_clearing ? clr_road : (accept && dec.road_we_lo && r_bank_sel);
    assign road_wd_hi   = r_clearing ? 8'h00 : dec.wdata_hi;
    assign road_wd_lo   = r_clearing ? 8'h00 : dec.wdata_lo;
    assign road_waddr   = r_clearing ? r_clr_cnt[ROAD_AW-1:0] : dec.road_cpu_addr;
    assign road_a_raddr = r_bank_sel ? dec.road_side_addr : dec.road_cpu_addr;
    assign road_b_raddr = r_bank_sel ? dec.road_cpu_addr : dec.road_side_addr;

    sbrd_ram #(.WIDTH(8), .DEPTH(ROAD_WORDS)) u_road_a_hi (
        .i_clk   (i_clk),
        .i_we    (road_a_we_hi),
        .i_waddr (road_waddr),
        .i_wdata (road_wd_hi),
        .i_raddr (road_a_raddr),
        .o_rdata (road_a_q[15:8])
    );

    sbrd_ram #(.WIDTH(8), .DEPTH(ROAD_WORDS)) u_road_a_lo (
        .i_clk   (i_clk),
        .i_we    (road_a_we_lo),
        .i_waddr (road_waddr),
        .i_wdata (road_wd_lo),
        .i_raddr (road_a_raddr),
        .o_rdata (road_a_q[7:0])
    );

    sbrd_ram #(.WIDTH(8), .DEPTH(ROAD_WORDS)) u_road_b_hi (
        .i_clk   (i_clk),
        .i_we    (road_b_we_hi),
        .i_waddr (road_waddr),
        .i_wdata (road_wd_hi),
        .i_raddr (road_b_raddr),
        .o_rdata (road_b_q[15:8])
    );

    sbrd_ram #(.WIDTH(8), .DEPTH(ROAD_WORDS)) u_road_b_lo (
        .i_clk   (i_clk),
        .i_we    (road_b_we_lo),
        .i_waddr (road_waddr),
        .i_wdata (road_wd_lo),
        .i_raddr (road_b_raddr),
        .o_rdata (road_b_q[7:0])
    );

    sbrd_result u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_s1_vld),
        .i_sel      (r_s1_sel),
        .i_mode     (r_s1_mode),
        .i_rom_q    (rom_q),
        .i_wram_q   (wram_q),
        .i_road_a_q (road_a_q),
        .i_road_b_q (road_b_q),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

endmodule

### hdl/sbrd_chk.sv
// Port-level checker for the sub-CPU bus decoder, bound to the top level.
// Depends on sbrd_pkg and sub_cpu_bus_with_road_double_buffer.
module sbrd_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           o_busy,
    input sbrd_pkg::t_cmd i_cmd,
    input logic           o_done,
    input sbrd_pkg::t_rsp o_rsp
);
    import sbrd_pkg::*;

    logic acc;
    assign acc = i_start && !o_busy;

    // The clearing pass starts right out of reset.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_busy)
        else $error("busy not raised after reset");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##2 o_done)
        else $error("accepted command gave no result two cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(acc, 2))
        else $error("result without an accepted command");

    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_cmd.action == ACT_WORD_WR || i_cmd.action == ACT_BYTE_WR ||
                 i_cmd.action == ACT_ROM_LD))
        |-> ##2 (o_rsp.read_data == 16'h0000))
        else $error("write command returned nonzero read data");

    a_byte_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_cmd.action == ACT_BYTE_RD) |-> ##2 (o_rsp.read_data[15:8] == 8'h00))
        else $error("byte read returned a nonzero upper byte");

endmodule

bind sub_cpu_bus_with_road_double_buffer sbrd_chk u_sbrd_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .i_cmd   (i_cmd),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
